// ===== rtl/core/nta_pkg.sv =====
// Shared types and constants for the neighbor table with aging.
// Used by every module of the block; depends on nothing.
package nta_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [31:0] TIMEOUT_RESET = 32'd3000;
  localparam logic [15:0] ID_MAX = 16'hFFFF;
  localparam logic [15:0] ID_FIRST = 16'd1;

  localparam logic OP_SEEN  = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  typedef enum logic [1:0] {
    ST_REFRESH = 2'd0,
    ST_INSERT  = 2'd1,
    ST_DROP    = 2'd2,
    ST_SWEEP   = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] last_seen;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } wr_cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } idx_cmd_t;

  typedef struct packed {
    logic live;
    logic match;
    logic id_gt;
    logic expired;
  } flags_t;

endpackage

// ===== rtl/core/nta_store.sv =====
// Entry storage: one registered read port, one write port, one clear port, per-entry valid bits.
// Depends on nta_pkg.
module nta_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nta_pkg::idx_cmd_t rd_cmd_i,
  input  nta_pkg::wr_cmd_t  wr_cmd_i,
  input  nta_pkg::idx_cmd_t clr_cmd_i,
  output nta_pkg::entry_t   rd_entry_o,
  output logic              rd_live_o
);
  import nta_pkg::*;

  entry_t           mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  entry_t           rd_entry_q;
  logic             rd_live_q;

  always_ff @(posedge clk_i) begin
    if (wr_cmd_i.en) begin
      mem_q[wr_cmd_i.idx] <= wr_cmd_i.entry;
    end
    if (rd_cmd_i.en) begin
      rd_entry_q <= mem_q[rd_cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_live_q <= 1'b0;
    end else begin
      if (rd_cmd_i.en) begin
        rd_live_q <= valid_q[rd_cmd_i.idx];
      end
      if (clr_cmd_i.en) begin
        valid_q[clr_cmd_i.idx] <= 1'b0;
      end
      if (wr_cmd_i.en) begin
        valid_q[wr_cmd_i.idx] <= 1'b1;
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_live_o  = rd_live_q;

endmodule

// ===== rtl/core/nta_cmp.sv =====
// Shared compare unit: checks one stored entry per cycle for match, id order and age.
// Depends on nta_pkg.
module nta_cmp (
  input  nta_pkg::entry_t entry_i,
  input  logic            live_i,
  input  logic [63:0]     addr_hi_i,
  input  logic [63:0]     addr_lo_i,
  input  logic [15:0]     max_id_i,
  input  logic [31:0]     limit_i,
  output nta_pkg::flags_t flags_o
);
  import nta_pkg::*;

  assign flags_o.live    = live_i;
  assign flags_o.match   = live_i && (entry_i.addr_hi == addr_hi_i)
                           && (entry_i.addr_lo == addr_lo_i);
  assign flags_o.id_gt   = live_i && (entry_i.id > max_id_i);
  assign flags_o.expired = live_i && (entry_i.last_seen <= limit_i);

endmodule

// ===== rtl/core/nta_seq.sv =====
// Sequencer: walks all entries once per item through the shared compare unit,
// clearing expired entries on a sweep, then commits a seen update and issues the result. Depends on nta_pkg.
module nta_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              opcode_i,
  input  logic [63:0]       addr_hi_i,
  input  logic [63:0]       addr_lo_i,
  input  logic [31:0]       now_i,
  input  logic [31:0]       timeout_i,
  input  nta_pkg::flags_t   flags_i,
  input  nta_pkg::entry_t   rd_entry_i,
  output logic [63:0]       addr_hi_o,
  output logic [63:0]       addr_lo_o,
  output logic [15:0]       max_id_o,
  output logic [31:0]       limit_o,
  output nta_pkg::idx_cmd_t rd_cmd_o,
  output nta_pkg::wr_cmd_t  wr_cmd_o,
  output nta_pkg::idx_cmd_t clr_cmd_o,
  output logic              result_valid_o,
  output logic [1:0]        status_o,
  output logic [15:0]       entry_id_o,
  output logic [4:0]        removed_count_o,
  output logic [4:0]        live_count_o
);
  import nta_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;
  logic             pend_q;
  logic [IDX_W-1:0] pidx_q;
  logic             op_q;
  logic [63:0]      addr_hi_q;
  logic [63:0]      addr_lo_q;
  logic [31:0]      now_q;
  logic [31:0]      limit_q;
  logic             any_q;
  logic [15:0]      max_id_q;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [15:0]      hit_id_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [CNT_W-1:0] removed_q;
  logic [CNT_W-1:0] live_q;
  logic             res_valid_q;
  status_e          res_status_q;
  logic [15:0]      res_id_q;
  logic [4:0]       res_removed_q;
  logic [4:0]       res_live_q;
  logic [15:0]      new_id;
  logic             do_insert;

  assign new_id    = !any_q ? ID_FIRST : (max_id_q == ID_MAX) ? ID_MAX : max_id_q + 16'd1;
  assign do_insert = (state_q == S_DONE) && (op_q == OP_SEEN) && !hit_q && free_q;

  always_comb begin
    rd_cmd_o.en  = (state_q == S_SCAN);
    rd_cmd_o.idx = cnt_q;

    clr_cmd_o.en  = pend_q && (op_q == OP_SWEEP) && flags_i.expired;
    clr_cmd_o.idx = pidx_q;

    wr_cmd_o.en                    = (state_q == S_DONE) && (op_q == OP_SEEN) && (hit_q || free_q);
    wr_cmd_o.idx                   = hit_q ? hit_idx_q : free_idx_q;
    wr_cmd_o.entry.addr_hi         = addr_hi_q;
    wr_cmd_o.entry.addr_lo         = addr_lo_q;
    wr_cmd_o.entry.last_seen       = now_q;
    wr_cmd_o.entry.id              = hit_q ? hit_id_q : new_id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      pidx_q        <= '0;
      op_q          <= OP_SEEN;
      any_q         <= 1'b0;
      max_id_q      <= '0;
      hit_q         <= 1'b0;
      hit_idx_q     <= '0;
      hit_id_q      <= '0;
      free_q        <= 1'b0;
      free_idx_q    <= '0;
      removed_q     <= '0;
      live_q        <= '0;
      res_valid_q   <= 1'b0;
      res_status_q  <= ST_REFRESH;
      res_id_q      <= '0;
      res_removed_q <= '0;
      res_live_q    <= '0;
    end else begin
      res_valid_q <= 1'b0;
      pend_q      <= rd_cmd_o.en;
      pidx_q      <= cnt_q;

      if (pend_q) begin
        if (op_q == OP_SWEEP) begin
          if (flags_i.expired) begin
            removed_q <= removed_q + CNT_W'(1);
            live_q    <= live_q - CNT_W'(1);
          end
        end else if (flags_i.live) begin
          any_q <= 1'b1;
          if (flags_i.id_gt) begin
            max_id_q <= rd_entry_i.id;
          end
          if (!hit_q && flags_i.match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= pidx_q;
            hit_id_q  <= rd_entry_i.id;
          end
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= pidx_q;
        end
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q   <= S_SCAN;
            cnt_q     <= '0;
            op_q      <= opcode_i;
            any_q     <= 1'b0;
            max_id_q  <= '0;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            removed_q <= '0;
          end
        end
        S_SCAN: begin
          if (cnt_q == IDX_W'(DEPTH - 1)) begin
            state_q <= S_LAST;
          end else begin
            cnt_q <= cnt_q + IDX_W'(1);
          end
        end
        S_LAST: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          state_q       <= S_IDLE;
          res_valid_q   <= 1'b1;
          res_removed_q <= 5'(removed_q);
          res_id_q      <= '0;
          res_live_q    <= 5'(live_q);
          if (op_q == OP_SWEEP) begin
            res_status_q <= ST_SWEEP;
          end else if (hit_q) begin
            res_status_q <= ST_REFRESH;
            res_id_q     <= hit_id_q;
          end else if (free_q) begin
            res_status_q <= ST_INSERT;
            res_id_q     <= new_id;
          end else begin
            res_status_q <= ST_DROP;
          end
          if (do_insert) begin
            live_q     <= live_q + CNT_W'(1);
            res_live_q <= 5'(live_q + CNT_W'(1));
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start) begin
      addr_hi_q <= addr_hi_i;
      addr_lo_q <= addr_lo_i;
      now_q     <= now_i;
      limit_q   <= now_i - timeout_i;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign addr_hi_o       = addr_hi_q;
  assign addr_lo_o       = addr_lo_q;
  assign max_id_o        = max_id_q;
  assign limit_o         = limit_q;
  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign entry_id_o      = res_id_q;
  assign removed_count_o = res_removed_q;
  assign live_count_o    = res_live_q;

endmodule

// ===== rtl/core/neighbor_table_with_aging.sv =====
// Top level of the neighbor table with aging: timeout register, sequencer,
// compare unit and entry storage. Depends on nta_pkg, nta_seq, nta_cmp, nta_store.
//
// Usage:
//   Item channel: drive opcode_i, addr_hi_i, addr_lo_i and now_i with start high;
//   the item is taken at the rising edge where start is high and busy is low.
//   opcode_i selects a seen operation (insert or refresh) or an aging sweep.
//   Result channel: one result per item, shown for exactly one cycle with
//   result_valid_o high. The receiver cannot stall; it must take it then.
//   Operation: busy stays high while the sequencer walks every entry through the
//   compare unit, one entry per cycle over the single storage read port, then
//   waits for the last registered read and commits; the result is shown as busy
//   falls. A new item is taken only after the previous item has been walked and
//   committed.
//   Configuration: cfg_data_i writes the timeout when cfg_valid_i is high;
//   cfg_ready_o is always high. Write it only while the block is idle.
//   Reset: asynchronous, active low. The table comes up empty and the
//   timeout comes up at 3000 ticks.
module neighbor_table_with_aging (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [63:0] addr_hi_i,
  input  logic [63:0] addr_lo_i,
  input  logic [31:0] now_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] entry_id_o,
  output logic [4:0]  removed_count_o,
  output logic [4:0]  live_count_o
);
  import nta_pkg::*;

  logic [31:0] timeout_q;
  flags_t      flags;
  entry_t      rd_entry;
  logic        rd_live;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [15:0] max_id;
  logic [31:0] limit;
  idx_cmd_t    rd_cmd;
  wr_cmd_t     wr_cmd;
  idx_cmd_t    clr_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  nta_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .addr_hi_i       (addr_hi_i),
    .addr_lo_i       (addr_lo_i),
    .now_i           (now_i),
    .timeout_i       (timeout_q),
    .flags_i         (flags),
    .rd_entry_i      (rd_entry),
    .addr_hi_o       (key_hi),
    .addr_lo_o       (key_lo),
    .max_id_o        (max_id),
    .limit_o         (limit),
    .rd_cmd_o        (rd_cmd),
    .wr_cmd_o        (wr_cmd),
    .clr_cmd_o       (clr_cmd),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .entry_id_o      (entry_id_o),
    .removed_count_o (removed_count_o),
    .live_count_o    (live_count_o)
  );

  nta_cmp u_cmp (
    .entry_i   (rd_entry),
    .live_i    (rd_live),
    .addr_hi_i (key_hi),
    .addr_lo_i (key_lo),
    .max_id_i  (max_id),
    .limit_i   (limit),
    .flags_o   (flags)
  );

  nta_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_cmd_i   (rd_cmd),
    .wr_cmd_i   (wr_cmd),
    .clr_cmd_i  (clr_cmd),
    .rd_entry_o (rd_entry),
    .rd_live_o  (rd_live)
  );

endmodule

// ===== rtl/core/nta_checker.sv =====
// Port-level checks for the neighbor table with aging, bound to the top level.
// Depends on nta_pkg and neighbor_table_with_aging.
module nta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [15:0] entry_id_o,
  input logic [4:0]  removed_count_o,
  input logic [4:0]  live_count_o
);
  import nta_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && !$past(result_valid_o)))
    else $error("result shown while busy or repeated");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_SWEEP)) |-> (removed_count_o == 5'd0))
    else $error("removed count on a seen item");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == ST_DROP)) |->
      ((entry_id_o == 16'd0) && (live_count_o == 5'(DEPTH))))
    else $error("drop without a full table");

  a_insert_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && ((status_o == ST_INSERT) || (status_o == ST_REFRESH))) |->
      ((entry_id_o != 16'd0) && (live_count_o != 5'd0)))
    else $error("seen item without a live id");

endmodule

bind neighbor_table_with_aging nta_checker u_nta_checker (.*);

// ===== dv/tb_neighbor_table_with_aging.sv =====
`timescale 1ns / 100ps
// Testbench for neighbor_table_with_aging: directed and random seen/sweep items,
// timeout rewrites between phases and a short id climb.
// Depends on nta_pkg and the RTL of the block; checks each result against its own table.
module tb_neighbor_table_with_aging;
  import nta_pkg::*;

  typedef struct {
    status_e     status;
    logic [15:0] id;
    logic [4:0]  removed;
    logic [4:0]  live;
  } outcome_t;

  class nta_scoreboard;
    logic [31:0] timeout;
    bit          slot_valid[DEPTH];
    logic [63:0] slot_hi[DEPTH];
    logic [63:0] slot_lo[DEPTH];
    logic [31:0] slot_seen[DEPTH];
    logic [15:0] slot_id[DEPTH];
    outcome_t    pending_q[$];
    int unsigned n_err, n_checked, n_insert, n_refresh, n_drops, n_sweeps, n_aged;
    logic [15:0] top_id;

    function new();
      timeout = TIMEOUT_RESET;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      top_id = '0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      n_err++;
    endtask

    function void note_item(logic op, logic [63:0] ahi, logic [63:0] alo, logic [31:0] now);
      outcome_t    o;
      int          hit, free_slot, n_live;
      logic [15:0] top;
      bit          any;
      logic [31:0] lim;
      o.status = ST_SWEEP;
      o.id = '0;
      o.removed = '0;
      hit = -1;
      free_slot = -1;
      top = '0;
      any = 1'b0;
      n_live = 0;
      if (op == OP_SWEEP) begin
        lim = now - timeout;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i] && slot_seen[i] <= lim) begin
            slot_valid[i] = 1'b0;
            o.removed++;
          end
        end
        n_sweeps++;
        n_aged += o.removed;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_valid[i]) begin
            any = 1'b1;
            if (slot_id[i] > top) top = slot_id[i];
            if (hit < 0 && slot_hi[i] == ahi && slot_lo[i] == alo) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          slot_seen[hit] = now;
          o.id = slot_id[hit];
          o.status = ST_REFRESH;
          n_refresh++;
        end else if (free_slot >= 0) begin
          o.id = !any ? ID_FIRST : (top == ID_MAX) ? ID_MAX : top + 16'd1;
          slot_valid[free_slot] = 1'b1;
          slot_hi[free_slot] = ahi;
          slot_lo[free_slot] = alo;
          slot_seen[free_slot] = now;
          slot_id[free_slot] = o.id;
          o.status = ST_INSERT;
          if (o.id > top_id) top_id = o.id;
          n_insert++;
        end else begin
          o.status = ST_DROP;
          n_drops++;
        end
      end
      foreach (slot_valid[i]) if (slot_valid[i]) n_live++;
      o.live = 5'(n_live);
      pending_q.push_back(o);
    endfunction

    task check_result(logic [1:0] st, logic [15:0] eid, logic [4:0] rm, logic [4:0] lv);
      outcome_t o;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with no item pending, status %0d", st));
        return;
      end
      o = pending_q.pop_front();
      n_checked++;
      if (st !== o.status) report_mismatch($sformatf("status %0d, want %0d", st, o.status));
      if (eid !== o.id) report_mismatch($sformatf("entry_id %0d, want %0d", eid, o.id));
      if (rm !== o.removed) report_mismatch($sformatf("removed_count %0d, want %0d", rm, o.removed));
      if (lv !== o.live) report_mismatch($sformatf("live_count %0d, want %0d", lv, o.live));
    endtask

    task check_drained();
      if (pending_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        opcode_i;
  logic [63:0] addr_hi_i;
  logic [63:0] addr_lo_i;
  logic [31:0] now_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [15:0] entry_id_o;
  logic [4:0]  removed_count_o;
  logic [4:0]  live_count_o;

  nta_scoreboard sb = new();
  int unsigned   n_sent;
  logic [31:0]   tick;
  logic [63:0]   pool_hi[24];
  logic [63:0]   pool_lo[24];

  neighbor_table_with_aging i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .opcode_i,
    .addr_hi_i,
    .addr_lo_i,
    .now_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .result_valid_o,
    .status_o,
    .entry_id_o,
    .removed_count_o,
    .live_count_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(opcode_i, addr_hi_i, addr_lo_i, now_i);
      if (result_valid_o) sb.check_result(status_o, entry_id_o, removed_count_o, live_count_o);
    end
  end

  task automatic send_item(input logic op, input logic [63:0] ahi, input logic [63:0] alo,
                           input logic [31:0] now);
    start <= 1'b1;
    opcode_i <= op;
    addr_hi_i <= ahi;
    addr_lo_i <= alo;
    now_i <= now;
    do @(posedge clk_i); while (busy);
    n_sent++;
  endtask

  task automatic hold_sender(input int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 3) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.timeout = val;
  endtask

  task automatic run_directed();
    logic [63:0] w;
    send_item(OP_SEEN, '0, '0, 32'd0);
    send_item(OP_SEEN, '1, '1, 32'hFFFF_FFFF);
    send_item(OP_SEEN, '0, '0, 32'd100);
    // limit lands exactly on the first entry's tick
    send_item(OP_SWEEP, '1, '1, 32'd3100);
    // limit wraps to all ones and clears the table
    send_item(OP_SWEEP, '0, '0, 32'd2999);
    for (int i = 0; i < DEPTH; i++) begin
      w = 64'h8000_0000_0000_0000 >> (i * 4);
      send_item(OP_SEEN, w, ~w, 32'(i));
    end
    send_item(OP_SEEN, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, 32'd50);
    send_item(OP_SEEN, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'd60);
    send_item(OP_SWEEP, '0, '1, 32'd3007);
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned idle_pct);
    logic        op;
    logic [63:0] ahi, alo;
    logic [31:0] now;
    int unsigned k;
    for (int i = 0; i < n_items; i++) begin
      op = ($urandom_range(99) < 15) ? OP_SWEEP : OP_SEEN;
      k = $urandom_range(23);
      if (op == OP_SEEN && $urandom_range(99) < 85) begin
        ahi = pool_hi[k];
        alo = pool_lo[k];
      end else begin
        ahi = {$urandom(), $urandom()};
        alo = {$urandom(), $urandom()};
      end
      tick = tick + $urandom_range(0, 40);
      now = ($urandom_range(99) < 90) ? tick : $urandom();
      send_item(op, ahi, alo, now);
      if (i % 100 == 50) wait_drained();
      else hold_sender(idle_pct);
    end
  endtask

  task automatic run_id_climb();
    int unsigned issued, batch;
    logic [31:0] t;
    issued = 0;
    batch = DEPTH;
    t = 32'd1;
    send_item(OP_SWEEP, '0, '0, 32'hFFFF_FFFF);
    // keep only the newest entry alive so every insert takes the next id
    while (issued < 8 * DEPTH) begin
      repeat (batch) begin
        send_item(OP_SEEN, 64'hC0DE_0000_0000_0001, 64'(issued), t);
        t++;
        issued++;
      end
      send_item(OP_SWEEP, {$urandom(), $urandom()}, {$urandom(), $urandom()}, t - 32'd2);
      batch = DEPTH - 1;
    end
  endtask

  initial begin
    start <= 1'b0;
    opcode_i <= OP_SEEN;
    addr_hi_i <= '0;
    addr_lo_i <= '0;
    now_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    n_sent = 0;
    tick = 32'hFFFF_F000;
    foreach (pool_hi[i]) begin
      pool_hi[i] = {$urandom(), $urandom()};
      pool_lo[i] = {$urandom(), $urandom()};
    end
    pool_hi[0] = '0;
    pool_lo[0] = '0;
    pool_hi[1] = '1;
    pool_lo[1] = '1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();
    write_timeout($urandom_range(20, 400));
    run_random(250, 0);
    wait_drained();
    write_timeout(32'hFFFF_FFFF);
    run_random(250, 67);
    wait_drained();
    write_timeout($urandom());
    run_random(250, 0);
    wait_drained();
    write_timeout($urandom_range(20, 400));
    run_random(250, 8);
    wait_drained();
    write_timeout(32'd0);
    run_id_climb();
    wait_drained();
    sb.check_drained();

    $display("Ran %0d items (%0d checked): %0d inserts, %0d refreshes, %0d drops, %0d sweeps.",
             n_sent, sb.n_checked, sb.n_insert, sb.n_refresh, sb.n_drops, sb.n_sweeps);
    $display("Sweeps aged out %0d entries; highest id issued %0d; %0d mismatches.",
             sb.n_aged, sb.top_id, sb.n_err);
    if (sb.n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Timed out with %0d results outstanding.", sb.pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/nta_pkg.sv
rtl/core/nta_store.sv
rtl/core/nta_cmp.sv
rtl/core/nta_seq.sv
rtl/core/neighbor_table_with_aging.sv
rtl/core/nta_checker.sv
dv/tb_neighbor_table_with_aging.sv
